[rtl/varint_nine_byte_codec_defines.svh]
// Assertion macros shared by the varint codec RTL.
// Included by modules that check their own behaviour; no other dependencies.
`ifndef VARINT_NINE_BYTE_CODEC_DEFINES_SVH
`define VARINT_NINE_BYTE_CODEC_DEFINES_SVH

// Implication within the same cycle, ignored while reset is high.
`define VNBC_ASSERT_SAME(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle, ignored while reset is high.
`define VNBC_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vnbc_pkg.sv]
// Shared types, constants and helper functions for the varint codec.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vnbc_pkg;

  localparam int GROUP_BITS  = 7;
  localparam int MAX_BYTES   = 9;
  localparam int TOP_SHIFT   = 56;
  localparam int VALUE_W     = 64;
  localparam int LEN_W       = 4;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 80;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;
  } dec_status_t;

  // Number of bytes the encoder emits for a value.
  function automatic logic [LEN_W-1:0] enc_length(input logic [VALUE_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = LEN_W'(1);
    for (int k = 1; k < MAX_BYTES - 1; k++) begin
      if (v[k*GROUP_BITS +: GROUP_BITS] != '0) begin
        n = LEN_W'(k + 1);
      end
    end
    if (v[VALUE_W-1:TOP_SHIFT] != '0) begin
      n = LEN_W'(MAX_BYTES);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/vnbc_decoder.sv]
// Decode accumulator: gathers 7-bit groups of one varint and reports completion.
// Depends on vnbc_pkg and the assertion macros in varint_nine_byte_codec_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "varint_nine_byte_codec_defines.svh"

module vnbc_decoder import vnbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  in_byte,
  output dec_status_t      status
);

  localparam logic [LEN_W-1:0] LAST_GROUP = LEN_W'(MAX_BYTES - 1);

  logic [VALUE_W-1:0] acc;
  logic [LEN_W-1:0]   cnt;
  logic [VALUE_W-1:0] acc_next;
  logic [LEN_W-1:0]   cnt_next;
  logic [5:0]         shamt;
  logic [VALUE_W-1:0] part;

  always_comb begin
    shamt    = 6'(cnt[2:0]) * 6'(GROUP_BITS);
    if (cnt == LAST_GROUP) begin
      part = VALUE_W'(in_byte) << TOP_SHIFT;
    end else begin
      part = VALUE_W'(in_byte[GROUP_BITS-1:0]) << shamt;
    end
    acc_next = acc | part;
    cnt_next = cnt + LEN_W'(1);
    status.done   = !in_byte[7] || (cnt_next == LEN_W'(MAX_BYTES));
    status.value  = acc_next;
    status.length = cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (take) begin
      if (status.done) begin
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= acc_next;
        cnt <= cnt_next;
      end
    end
  end

  `VNBC_ASSERT_SAME(a_cnt_range, clk, rst, 1'b1, cnt <= LAST_GROUP, "decode byte count above eight")
  `VNBC_ASSERT_SAME(a_ninth_done, clk, rst, take && cnt == LAST_GROUP, status.done, "ninth byte kept open")
  `VNBC_ASSERT_NEXT(a_clear_after_done, clk, rst, take && status.done, cnt == '0 && acc == '0, "decoder state not cleared")

endmodule

`default_nettype wire

[rtl/varint_nine_byte_codec.sv]
// Top level of the nine-byte-capped varint codec: stream ports, sequencer, encode shifter.
// Depends on vnbc_pkg, vnbc_decoder and varint_nine_byte_codec_defines.svh.
//
// Usage: one input stream carries transactions; s_axis_tuser selects encode (0) or
// decode (1). An encode transaction takes a 64-bit value and produces one to nine
// output transactions, one encoded byte each, least significant group first, with
// m_axis_tlast on the final byte. The byte count is found on acceptance and a
// 7-bit right shifter then produces one byte per cycle while the receiver is
// ready. The accepting edge loads the shifter and enters ST_ENC, which then
// registers each byte into the output. A decode transaction takes one byte; the
// byte that completes a value yields one output transaction (m_axis_tuser high, tlast
// high), valid straight after the accepting edge, and s_axis_tready is then low
// until the receiver takes it. The block works on one transaction at a time and
// s_axis_tready is low while it is busy. When the receiver stalls, the pending
// output is held unchanged and the sequencer waits. Reset clears the sequencer,
// the output valid flag and any partially decoded value.
`timescale 1ns / 1ps
`default_nettype none
`include "varint_nine_byte_codec_defines.svh"

module varint_nine_byte_codec import vnbc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value[63:0], in_byte[71:64]
  input  wire logic                   s_axis_tuser,   // command
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // out_byte, decoded_value, length, pad
  output logic                        m_axis_tuser,   // is_decoded
  output logic                        m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENC,
    ST_OUT
  } state_t;

  localparam logic [LEN_W-1:0] NINTH = LEN_W'(MAX_BYTES - 1);

  state_t             state;
  logic [VALUE_W-1:0] sh;
  logic [LEN_W-1:0]   enc_len;
  logic [LEN_W-1:0]   enc_idx;
  logic [7:0]         out_byte;
  logic [VALUE_W-1:0] out_value;
  logic [LEN_W-1:0]   out_length;
  logic               out_last;
  logic               out_isdec;

  logic               accept;
  logic               dec_take;
  logic [VALUE_W-1:0] in_value;
  logic [7:0]         in_byte;
  logic               enc_final;
  logic [7:0]         enc_byte;
  dec_status_t        dec_status;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_value      = s_axis_tdata[VALUE_W-1:0];
  assign in_byte       = s_axis_tdata[IN_TDATA_W-1:VALUE_W];
  assign dec_take      = accept && (s_axis_tuser == CMD_DECODE);

  assign enc_final = (enc_idx == enc_len - LEN_W'(1));
  assign enc_byte  = (enc_idx == NINTH) ? sh[7:0] : {!enc_final, sh[GROUP_BITS-1:0]};

  assign m_axis_tdata = {(OUT_TDATA_W - 8 - VALUE_W - LEN_W)'(0), out_length, out_value,
                         out_byte};
  assign m_axis_tuser = out_isdec;
  assign m_axis_tlast = out_last;

  vnbc_decoder u_dec (
    .clk     (clk),
    .rst     (rst),
    .take    (dec_take),
    .in_byte (in_byte),
    .status  (dec_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      enc_idx       <= '0;
      enc_len       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == CMD_ENCODE) begin
              sh      <= in_value;
              enc_len <= enc_length(in_value);
              enc_idx <= '0;
              state   <= ST_ENC;
            end else if (dec_status.done) begin
              out_byte      <= '0;
              out_value     <= dec_status.value;
              out_length    <= dec_status.length;
              out_last      <= 1'b1;
              out_isdec     <= 1'b1;
              m_axis_tvalid <= 1'b1;
              state         <= ST_OUT;
            end
          end
        end
        ST_ENC: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_byte      <= enc_byte;
            out_value     <= '0;
            out_length    <= enc_len;
            out_last      <= enc_final;
            out_isdec     <= 1'b0;
            m_axis_tvalid <= 1'b1;
            sh            <= sh >> GROUP_BITS;
            enc_idx       <= enc_idx + LEN_W'(1);
            if (enc_final) begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `VNBC_ASSERT_SAME(a_idle_drained, clk, rst, s_axis_tready, !m_axis_tvalid, "output pending while ready")
  `VNBC_ASSERT_SAME(a_enc_index, clk, rst, state == ST_ENC, enc_idx < enc_len, "encode index past length")
  `VNBC_ASSERT_SAME(a_dec_last, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "decode result without last")
  `VNBC_ASSERT_SAME(a_cont_bit, clk, rst, m_axis_tvalid && !m_axis_tuser && !m_axis_tlast, m_axis_tdata[7], "inner byte lacks continuation")

endmodule

`default_nettype wire
